FILE: rtl/velocity_limiter_with_watchdog_top_macros.svh
// Assertion macros shared by the velocity limiter RTL.
`ifndef VELOCITY_LIMITER_WITH_WATCHDOG_TOP_MACROS_SVH
`define VELOCITY_LIMITER_WITH_WATCHDOG_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define VLW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define VLW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/vlw_pkg.sv
// Shared types and constants for the velocity limiter.
package vlw_pkg;

    localparam int VEL_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int LIMIT_W       = 31;
    localparam int TIMEOUT_W     = 16;
    localparam int AGE_W         = 16;
    localparam int OP_W          = 2;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 16;

    localparam logic [AGE_W-1:0]     AGE_MAX       = 16'hFFFF;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd200;

    typedef enum logic [OP_W-1:0] {
        OP_CMD   = 2'd0,
        OP_LIMIT = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = 1'b1;

    // Control for the bit-serial arithmetic units.
    typedef struct packed {
        logic load;
        logic step;
        logic last;
    } ser_ctl_t;

endpackage

FILE: rtl/vlw_div.sv
// Restoring divider producing one ratio bit per cycle: floor(num * 2^FRAC_BITS / den).
module vlw_div #(
    parameter int VEL_WIDTH = vlw_pkg::VEL_WIDTH_DEF,
    parameter int FRAC_BITS = vlw_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  vlw_pkg::ser_ctl_t      ctl,
    input  logic [VEL_WIDTH-1:0]   num,
    input  logic [VEL_WIDTH-1:0]   den,
    output logic [FRAC_BITS:0]     quot
);
    import vlw_pkg::*;

    logic [VEL_WIDTH:0]   rem_reg;
    logic [VEL_WIDTH:0]   rem_next;
    logic [VEL_WIDTH:0]   rem_sel;
    logic [VEL_WIDTH:0]   diff;
    logic [VEL_WIDTH-1:0] den_reg;
    logic [FRAC_BITS:0]   quot_reg;
    logic [FRAC_BITS:0]   quot_next;
    logic                 ge;

    always_comb
    begin
        diff      = rem_reg - {1'b0, den_reg};
        ge        = (rem_reg >= {1'b0, den_reg});
        rem_sel   = ge ? diff : rem_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (ctl.load)
        begin
            rem_next  = {1'b0, num};
            quot_next = '0;
        end
        else if (ctl.step)
        begin
            quot_next = {quot_reg[FRAC_BITS-1:0], ge};
            // remainder stays below den, so the top bit drops out of the shift
            if (ctl.last)
                rem_next = rem_sel;
            else
                rem_next = {rem_sel[VEL_WIDTH-1:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        if (ctl.load)
            den_reg <= den;
    end

    assign quot = quot_reg;

endmodule

FILE: rtl/vlw_mul.sv
// Shift-and-add multiplier, one ratio bit per cycle: floor(mag * ratio / 2^FRAC_BITS).
module vlw_mul #(
    parameter int VEL_WIDTH = vlw_pkg::VEL_WIDTH_DEF,
    parameter int FRAC_BITS = vlw_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  vlw_pkg::ser_ctl_t      ctl,
    input  logic [VEL_WIDTH-1:0]   mag,
    input  logic [FRAC_BITS:0]     ratio,
    output logic [VEL_WIDTH-1:0]   prod
);
    import vlw_pkg::*;

    logic [VEL_WIDTH-1:0] m_reg;
    logic [FRAC_BITS:0]   r_reg;
    logic [VEL_WIDTH:0]   hi_reg;
    logic [VEL_WIDTH:0]   hi_next;
    logic [VEL_WIDTH:0]   sum;

    always_comb
    begin
        sum     = hi_reg + (r_reg[0] ? {1'b0, m_reg} : '0);
        hi_next = hi_reg;
        if (ctl.load)
            hi_next = '0;
        else if (ctl.step)
        begin
            // the top ratio bit has weight one after the fraction bits drop out
            if (ctl.last)
                hi_next = sum;
            else
                hi_next = {1'b0, sum[VEL_WIDTH:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        if (ctl.load)
        begin
            m_reg <= mag;
            r_reg <= ratio;
        end
        else if (ctl.step)
            r_reg <= {1'b0, r_reg[FRAC_BITS:1]};
    end

    assign prod = hi_reg[VEL_WIDTH-1:0];

endmodule

FILE: rtl/velocity_limiter_with_watchdog_top.sv
// Velocity command limiter with speed-limit watchdog: top level.
//
// Input stream s_*: s_tuser carries the item kind (0 command, 1 limit update, 2 tick;
// 3 is dropped). A command yields one result on m_*; limit updates and ticks yield none
// and are taken without leaving the idle state. Configuration writes arrive on cfg_* (index 0 angular
// scaling enable, index 1 timeout in ticks, 0 disables) and are always ready.
// Sequence: a stale command passes the clamp state and goes straight to the output stage. A fresh command
// with scaling on runs three serial dividers that produce the clamp ratios one bit per cycle,
// then two serial multipliers that scale the angular pair of each axis one bit per cycle;
// with scaling off the dividers still run but every multiply pass is skipped.
// An axis whose command is zero skips its multiply pass.
// The input is ready again at the edge that registers the result, so commands go
// one at a time.
// Reset: limit 0, limit age saturated (stale), scaling on, timeout 200 ticks.
// The result sits in an output register; while the receiver stalls, the block keeps
// taking ticks and limit updates, and a finished command waits for the register.
`include "velocity_limiter_with_watchdog_top_macros.svh"

module velocity_limiter_with_watchdog_top #(
    parameter int   VEL_WIDTH = vlw_pkg::VEL_WIDTH_DEF,
    parameter int   FRAC_BITS = vlw_pkg::FRAC_BITS_DEF,
    localparam int  S_DATA_W  = ((6 * VEL_WIDTH + vlw_pkg::LIMIT_W + 7) / 8) * 8,
    localparam int  M_DATA_W  = ((6 * VEL_WIDTH + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, limit_value
    input  logic [S_DATA_W-1:0]               s_tdata,
    // op
    input  logic [vlw_pkg::OP_W-1:0]          s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y, out_ang_z
    output logic [M_DATA_W-1:0]               m_tdata,
    // timed_out
    output logic [0:0]                        m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vlw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [vlw_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import vlw_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam int CW    = ((VEL_WIDTH > LIMIT_W) ? VEL_WIDTH : LIMIT_W) + 2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_DIV,
        ST_MLOAD,
        ST_MRUN,
        ST_MWB,
        ST_FIN
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [1:0]           axis_reg, axis_next;
    logic [LIMIT_W-1:0]   limit_reg, limit_next;
    logic [AGE_W-1:0]     age_reg, age_next;
    logic                 scale_reg, scale_next;
    logic [TIMEOUT_W-1:0] timeout_reg, timeout_next;
    logic                 out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0]  out_data_reg, out_data_next;
    logic                 out_user_reg, out_user_next;

    logic [VEL_WIDTH-1:0] lin_reg [3];
    logic [VEL_WIDTH-1:0] cl_reg [3];
    logic                 lin_nz_reg [3];
    logic                 ang_sign_reg [3];
    logic [VEL_WIDTH-1:0] ang_mag_reg [3];
    logic                 stale_reg;

    logic [VEL_WIDTH-1:0] lin_in [3];
    logic [VEL_WIDTH-1:0] ang_in [3];
    logic [VEL_WIDTH-1:0] ang_in_mag [3];
    logic [LIMIT_W-1:0]   limit_in;
    op_t                  op_in;
    logic                 in_fire;
    logic                 fresh;

    logic [CW-1:0]        v_ext [3];
    logic [CW-1:0]        lim_ext;
    logic [CW-1:0]        neg_lim;
    logic [VEL_WIDTH-1:0] lin_mag [3];
    logic [VEL_WIDTH-1:0] cl_val [3];
    logic [VEL_WIDTH-1:0] cl_mag [3];
    logic [FRAC_BITS:0]   ratio [3];

    ser_ctl_t             div_ctl;
    ser_ctl_t             mul_ctl;
    logic [VEL_WIDTH-1:0] opa_mag;
    logic [VEL_WIDTH-1:0] opb_mag;
    logic [FRAC_BITS:0]   ratio_sel;
    logic                 nz_sel;
    logic [VEL_WIDTH-1:0] prod_a;
    logic [VEL_WIDTH-1:0] prod_b;
    logic [M_DATA_W-1:0]  out_pack;

    // Input unpacking
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lin_in[i]     = s_tdata[i*VEL_WIDTH +: VEL_WIDTH];
            ang_in[i]     = s_tdata[(3+i)*VEL_WIDTH +: VEL_WIDTH];
            ang_in_mag[i] = ang_in[i][VEL_WIDTH-1] ? (VEL_WIDTH'(0) - ang_in[i]) : ang_in[i];
        end
    end

    assign limit_in  = s_tdata[6*VEL_WIDTH +: LIMIT_W];
    assign op_in     = op_t'(s_tuser);
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign fresh     = (timeout_reg == '0) || (age_reg < timeout_reg);

    // Clamp each linear axis to plus or minus the limit
    assign lim_ext = {{(CW-LIMIT_W){1'b0}}, limit_reg};
    assign neg_lim = CW'(0) - lim_ext;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            v_ext[i]   = {{(CW-VEL_WIDTH){lin_reg[i][VEL_WIDTH-1]}}, lin_reg[i]};
            lin_mag[i] = lin_reg[i][VEL_WIDTH-1] ? (VEL_WIDTH'(0) - lin_reg[i]) : lin_reg[i];
            if ($signed(v_ext[i]) > $signed(lim_ext))
            begin
                cl_val[i] = lim_ext[VEL_WIDTH-1:0];
                cl_mag[i] = lim_ext[VEL_WIDTH-1:0];
            end
            else if ($signed(v_ext[i]) < $signed(neg_lim))
            begin
                cl_val[i] = neg_lim[VEL_WIDTH-1:0];
                cl_mag[i] = lim_ext[VEL_WIDTH-1:0];
            end
            else
            begin
                cl_val[i] = lin_reg[i];
                cl_mag[i] = lin_mag[i];
            end
        end
    end

    // One ratio per axis, all three at once
    for (genvar g = 0; g < 3; g++)
    begin : g_div
        vlw_div #(
            .VEL_WIDTH (VEL_WIDTH),
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk  (clk),
            .ctl  (div_ctl),
            .num  (cl_mag[g]),
            .den  (lin_mag[g]),
            .quot (ratio[g])
        );
    end

    // Each axis ratio scales the two other angular components
    always_comb
    begin
        unique case (axis_reg)
            AXIS_X:
            begin
                opa_mag   = ang_mag_reg[1];
                opb_mag   = ang_mag_reg[2];
                ratio_sel = ratio[0];
                nz_sel    = lin_nz_reg[0];
            end
            AXIS_Y:
            begin
                opa_mag   = ang_mag_reg[0];
                opb_mag   = ang_mag_reg[2];
                ratio_sel = ratio[1];
                nz_sel    = lin_nz_reg[1];
            end
            default:
            begin
                opa_mag   = ang_mag_reg[0];
                opb_mag   = ang_mag_reg[1];
                ratio_sel = ratio[2];
                nz_sel    = lin_nz_reg[2];
            end
        endcase
    end

    vlw_mul #(
        .VEL_WIDTH (VEL_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_mul_a (
        .clk   (clk),
        .ctl   (mul_ctl),
        .mag   (opa_mag),
        .ratio (ratio_sel),
        .prod  (prod_a)
    );

    vlw_mul #(
        .VEL_WIDTH (VEL_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_mul_b (
        .clk   (clk),
        .ctl   (mul_ctl),
        .mag   (opb_mag),
        .ratio (ratio_sel),
        .prod  (prod_b)
    );

    // Result packing
    always_comb
    begin
        out_pack = '0;
        for (int i = 0; i < 3; i++)
        begin
            out_pack[i*VEL_WIDTH +: VEL_WIDTH]     = cl_reg[i];
            out_pack[(3+i)*VEL_WIDTH +: VEL_WIDTH] = ang_sign_reg[i]
                ? (VEL_WIDTH'(0) - ang_mag_reg[i]) : ang_mag_reg[i];
        end
    end

    // Sequencer, watchdog and configuration
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        axis_next      = axis_reg;
        limit_next     = limit_reg;
        age_next       = age_reg;
        scale_next     = scale_reg;
        timeout_next   = timeout_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        div_ctl        = '0;
        mul_ctl        = '0;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SCALE:   scale_next   = cfg_data[0];
                CFG_TIMEOUT: timeout_next = cfg_data[TIMEOUT_W-1:0];
                default:     ;
            endcase
        end

        if (m_tvalid && m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (op_in)
                        OP_CMD:
                            state_next = ST_CLAMP;
                        OP_LIMIT:
                        begin
                            limit_next = limit_in;
                            age_next   = '0;
                        end
                        OP_TICK:
                        begin
                            if (age_reg != AGE_MAX)
                                age_next = age_reg + AGE_W'(1);
                        end
                        default: ;
                    endcase
                end
            end
            ST_CLAMP:
            begin
                div_ctl.load = 1'b1;
                cnt_next     = '0;
                state_next   = stale_reg ? ST_FIN : ST_DIV;
            end
            ST_DIV:
            begin
                div_ctl.step = 1'b1;
                div_ctl.last = (cnt_reg == CNT_W'(FRAC_BITS));
                cnt_next     = cnt_reg + CNT_W'(1);
                if (div_ctl.last)
                begin
                    axis_next  = AXIS_X;
                    state_next = ST_MLOAD;
                end
            end
            ST_MLOAD:
            begin
                // skip an axis whose command is zero, or every axis with scaling off
                if (scale_reg && nz_sel)
                begin
                    mul_ctl.load = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_MRUN;
                end
                else if (axis_reg == AXIS_Z)
                    state_next = ST_FIN;
                else
                    axis_next = axis_reg + 2'd1;
            end
            ST_MRUN:
            begin
                mul_ctl.step = 1'b1;
                mul_ctl.last = (cnt_reg == CNT_W'(FRAC_BITS));
                cnt_next     = cnt_reg + CNT_W'(1);
                if (mul_ctl.last)
                    state_next = ST_MWB;
            end
            ST_MWB:
            begin
                if (axis_reg == AXIS_Z)
                    state_next = ST_FIN;
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_MLOAD;
                end
            end
            ST_FIN:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = stale_reg ? '0 : out_pack;
                    out_user_next  = stale_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            axis_reg      <= AXIS_X;
            limit_reg     <= '0;
            age_reg       <= AGE_MAX;
            scale_reg     <= 1'b1;
            timeout_reg   <= TIMEOUT_RESET;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            axis_reg      <= axis_next;
            limit_reg     <= limit_next;
            age_reg       <= age_next;
            scale_reg     <= scale_next;
            timeout_reg   <= timeout_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_user_reg  <= out_user_next;
        end
    end

    // Command payload and working values
    always_ff @(posedge clk)
    begin
        if (in_fire && op_in == OP_CMD)
        begin
            stale_reg <= !fresh;
            for (int i = 0; i < 3; i++)
            begin
                lin_reg[i]      <= lin_in[i];
                ang_sign_reg[i] <= ang_in[i][VEL_WIDTH-1];
                ang_mag_reg[i]  <= ang_in_mag[i];
            end
        end
        if (state_reg == ST_CLAMP)
        begin
            for (int i = 0; i < 3; i++)
            begin
                cl_reg[i]     <= cl_val[i];
                lin_nz_reg[i] <= (lin_reg[i] != '0);
            end
        end
        if (state_reg == ST_MWB)
        begin
            unique case (axis_reg)
                AXIS_X:
                begin
                    ang_mag_reg[1] <= prod_a;
                    ang_mag_reg[2] <= prod_b;
                end
                AXIS_Y:
                begin
                    ang_mag_reg[0] <= prod_a;
                    ang_mag_reg[2] <= prod_b;
                end
                default:
                begin
                    ang_mag_reg[0] <= prod_a;
                    ang_mag_reg[1] <= prod_b;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `VLW_ASSERT_IMP(a_stale_zero, m_tvalid && m_tuser[0], m_tdata == '0, "stale result carries nonzero data")
    `VLW_ASSERT_NEXT(a_age_sat, in_fire && op_in == OP_TICK && age_reg == AGE_MAX, age_reg == AGE_MAX, "limit age wrapped")
    `VLW_ASSERT_NEXT(a_limit_age, in_fire && op_in == OP_LIMIT, age_reg == '0, "limit update left age set")
    `VLW_ASSERT_NEXT(a_fin_hold, state_reg == ST_FIN && m_tvalid && !m_tready, state_reg == ST_FIN && m_tvalid, "pending result overwritten")
    `VLW_ASSERT_IMP(a_cnt_range, state_reg == ST_DIV || state_reg == ST_MRUN, cnt_reg <= CNT_W'(FRAC_BITS), "bit counter out of range")

endmodule
